### hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants shared by the priority tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int SLOT_W  = 4;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 24;

    localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic               command;
        logic [SLOT_W-1:0]  slot;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic              idle;
        logic [SLOT_W-1:0] run_slot;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_out_item;

    typedef struct packed {
        logic [BURST_W-1:0] work;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

endpackage

`default_nettype wire

### hw/rtl/priority_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_tick_scheduler_unit
// Picks the live slot with the lowest priority number each tick.
// Load item: accepted while idle, no result.
// Tick item: one slot scanned per cycle through the slot memory read port and a
// single priority comparator; the chosen slot is then fetched and its work
// decremented (skipped when no slot is live); the next item is taken only once
// the result has moved into the output register, so output stall holds it off.
// Reset clears the live bits and the clock; slot memory contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_tick_scheduler_unit #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pts_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pts_pkg::t_out_item      o_out_item
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int XW = (IW > pts_pkg::SLOT_W) ? IW : pts_pkg::SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_UPDATE,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             r_cmp_idx;
    logic                      r_cmp_on;
    logic                      r_found;
    logic [IW-1:0]             r_best;
    logic [pts_pkg::PRIO_W-1:0] r_best_prio;
    logic [pts_pkg::TIME_W-1:0] r_clock;
    pts_pkg::t_out_item        r_res;
    pts_pkg::t_out_item        n_res;
    pts_pkg::t_out_item        r_out;
    logic                      r_out_valid;

    logic                      in_acc;
    logic [XW-1:0]             slot_x;
    logic                      slot_ok;
    logic [IW-1:0]             rd_addr;
    pts_pkg::t_entry           rd_data;
    logic                      rd_live;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    pts_pkg::t_entry           wr_data;
    logic [pts_pkg::BURST_W-1:0] work_dec;
    logic [pts_pkg::TIME_W-1:0] turn;
    logic [pts_pkg::TIME_W-1:0] burst_x;
    logic [XW-1:0]             best_x;
    logic                      out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign slot_x      = XW'(i_in_item.slot);
    assign slot_ok     = (32'(i_in_item.slot) < 32'(SLOTS));
    assign out_free    = !r_out_valid || !i_out_stall;

    assign rd_addr     = (r_state == ST_FETCH) ? r_best : r_idx;
    assign work_dec    = rd_data.work - 1'b1;
    assign turn        = (r_clock == pts_pkg::CLOCK_MAX) ? r_clock : r_clock + 1'b1;
    assign burst_x     = pts_pkg::TIME_W'(rd_data.burst);
    assign best_x      = XW'(r_best);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best;
        wr_data = rd_data;
        if (in_acc && (i_in_item.command == pts_pkg::CMD_LOAD) && slot_ok) begin
            wr_en        = 1'b1;
            wr_addr      = slot_x[IW-1:0];
            wr_data.work  = i_in_item.burst;
            wr_data.prio  = i_in_item.priority_req;
            wr_data.burst = i_in_item.burst;
        end else if (r_state == ST_UPDATE) begin
            wr_en        = 1'b1;
            wr_data.work = work_dec;
        end
    end

    always_comb begin
        n_res = '0;
        if (r_found) begin
            n_res.run_slot = best_x[pts_pkg::SLOT_W-1:0];
            if (work_dec == '0) begin
                n_res.finished   = 1'b1;
                n_res.turnaround = turn;
                n_res.waiting    = (turn >= burst_x) ? turn - burst_x : '0;
            end
        end else begin
            n_res.idle = 1'b1;
        end
    end

    pts_slot_table #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_rd_live (rd_live)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
            r_cmp_on    <= 1'b0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_prio <= '0;
            r_clock     <= '0;
            r_res       <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_cmp_on && rd_live && (!r_found || (rd_data.prio < r_best_prio))) begin
                r_best      <= r_cmp_idx;
                r_best_prio <= rd_data.prio;
                r_found     <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in_item.command == pts_pkg::CMD_TICK)) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cmp_idx <= r_idx;
                    r_cmp_on  <= 1'b1;
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_cmp_on <= 1'b0;
                    r_state  <= ST_FETCH;
                end
                ST_FETCH: begin
                    if (r_found) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_res   <= n_res;
                        r_state <= ST_OUT;
                    end
                end
                ST_UPDATE: begin
                    r_res   <= n_res;
                    r_clock <= turn;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### hw/rtl/pts_slot_table.sv
// ----------------------------------------------------------------------------
// pts_slot_table
// Slot memory with one read and one write port and a live bit per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_slot_table #(
    parameter int SLOTS = pts_pkg::SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_en,
    input  wire logic [IW-1:0]  i_wr_addr,
    input  wire pts_pkg::t_entry i_wr_data,
    input  wire logic [IW-1:0]  i_rd_addr,
    output pts_pkg::t_entry     o_rd_data,
    output logic                o_rd_live
);

    pts_pkg::t_entry r_mem [SLOTS];
    logic [SLOTS-1:0] r_live;
    pts_pkg::t_entry r_rd;
    logic            r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_live[i_wr_addr] <= (i_wr_data.work != '0);
            end
            r_rd_live <= r_live[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_rd_live = r_rd_live;

endmodule

`default_nettype wire

### hw/rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the priority tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire pts_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pts_pkg::t_out_item o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.command == pts_pkg::CMD_TICK) |=> o_in_stall)
        else $error("tick item did not occupy the scheduler");

    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.command == pts_pkg::CMD_LOAD) |=> !$rose(o_out_valid))
        else $error("load item produced a result");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.idle |-> (o_out_item.run_slot == '0)
            && !o_out_item.finished && (o_out_item.turnaround == '0)
            && (o_out_item.waiting == '0))
        else $error("idle result carries slot data");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |->
            (o_out_item.waiting < o_out_item.turnaround) && !o_out_item.idle)
        else $error("waiting time not below turnaround");

endmodule

bind priority_tick_scheduler_unit pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
